>>> sv/tsn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tsn_pkg;

  // result row kinds
  typedef enum logic [3:0] {
    ROW_P0      = 4'd0,
    ROW_P1      = 4'd1,
    ROW_P2      = 4'd2,
    ROW_NORMAL  = 4'd3,
    ROW_BOX_MIN = 4'd4,
    ROW_BOX_MAX = 4'd5,
    ROW_OBJECT  = 4'd6,
    ROW_REJECT  = 4'd7,
    ROW_CLEAR   = 4'd8
  } row_e;

  // datapath operations
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_ACCEPT,
    OP_BOX,
    OP_EDGE,
    OP_MUL,
    OP_MAX,
    OP_NORM,
    OP_SQ,
    OP_SQRT,
    OP_DIV
  } op_e;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_BOX,
    S_EDGE,
    S_MUL,
    S_MAX,
    S_NORM,
    S_SQ,
    S_SQRT,
    S_DIV,
    S_EMIT
  } state_e;

  // input commands
  localparam logic CMD_TRIANGLE = 1'b0;
  localparam logic CMD_CLEAR    = 1'b1;

  // register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MATERIAL_ID    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_TAG     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MESH_TRIANGLES = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIANGLES  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_OBJECTS    = 3'd7;

  // step counts of the iterative units
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned MUL_STEPS  = 6;
  localparam int unsigned SQ_STEPS   = 3;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 47;

  localparam logic signed [31:0] BOX_MIN_INIT = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] BOX_MAX_INIT = 32'sh8000_0000;

  typedef struct packed {
    op_e              op;
    logic [CNT_W-1:0] idx;
    row_e             row;
  } cmd_t;

  typedef struct packed {
    logic rej_now;
    logic ending;
    logic norm_done;
    logic zero;
  } sts_t;

endpackage
`default_nettype wire

>>> sv/tsn_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tsn_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          command_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic               last_o,
  output tsn_pkg::cmd_t      cmd_o,
  input  wire tsn_pkg::sts_t sts_i
);

  tsn_pkg::state_e                state_q, state_d;
  logic [tsn_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  tsn_pkg::row_e                  row_q, row_d;
  logic                           last_row;

  // final row of the item
  assign last_row = (row_q == tsn_pkg::ROW_CLEAR) || (row_q == tsn_pkg::ROW_REJECT) ||
                    (row_q == tsn_pkg::ROW_OBJECT) ||
                    ((row_q == tsn_pkg::ROW_NORMAL) && !sts_i.ending);

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    row_d   = row_q;
    case (state_q)
      tsn_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (command_i == tsn_pkg::CMD_CLEAR) begin
            state_d = tsn_pkg::S_EMIT;
            row_d   = tsn_pkg::ROW_CLEAR;
          end else if (sts_i.rej_now) begin
            state_d = tsn_pkg::S_EMIT;
            row_d   = tsn_pkg::ROW_REJECT;
          end else begin
            state_d = tsn_pkg::S_BOX;
          end
        end
      end
      tsn_pkg::S_BOX: state_d = tsn_pkg::S_EDGE;
      tsn_pkg::S_EDGE: begin
        state_d = tsn_pkg::S_MUL;
        cnt_d   = '0;
      end
      tsn_pkg::S_MUL: begin
        if (cnt_q == tsn_pkg::CNT_W'(tsn_pkg::MUL_STEPS)) begin
          state_d = tsn_pkg::S_MAX;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      tsn_pkg::S_MAX: state_d = tsn_pkg::S_NORM;
      tsn_pkg::S_NORM: begin
        if (sts_i.norm_done) begin
          cnt_d = '0;
          if (sts_i.zero) begin
            state_d = tsn_pkg::S_EMIT;
            row_d   = tsn_pkg::ROW_P0;
          end else begin
            state_d = tsn_pkg::S_SQ;
          end
        end
      end
      tsn_pkg::S_SQ: begin
        if (cnt_q == tsn_pkg::CNT_W'(tsn_pkg::SQ_STEPS)) begin
          state_d = tsn_pkg::S_SQRT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      tsn_pkg::S_SQRT: begin
        if (cnt_q == tsn_pkg::CNT_W'(tsn_pkg::SQRT_STEPS - 1)) begin
          state_d = tsn_pkg::S_DIV;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      tsn_pkg::S_DIV: begin
        if (cnt_q == tsn_pkg::CNT_W'(tsn_pkg::DIV_STEPS - 1)) begin
          state_d = tsn_pkg::S_EMIT;
          row_d   = tsn_pkg::ROW_P0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      tsn_pkg::S_EMIT: begin
        if (out_ready_i) begin
          if (last_row) begin
            state_d = tsn_pkg::S_IDLE;
          end else begin
            case (row_q)
              tsn_pkg::ROW_P0:      row_d = tsn_pkg::ROW_P1;
              tsn_pkg::ROW_P1:      row_d = tsn_pkg::ROW_P2;
              tsn_pkg::ROW_P2:      row_d = tsn_pkg::ROW_NORMAL;
              tsn_pkg::ROW_NORMAL:  row_d = tsn_pkg::ROW_BOX_MIN;
              tsn_pkg::ROW_BOX_MIN: row_d = tsn_pkg::ROW_BOX_MAX;
              tsn_pkg::ROW_BOX_MAX: row_d = tsn_pkg::ROW_OBJECT;
              default:              row_d = row_q;
            endcase
          end
        end
      end
      default: state_d = tsn_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    last_o      = 1'b0;
    cmd_o.op    = tsn_pkg::OP_IDLE;
    cmd_o.idx   = cnt_q;
    cmd_o.row   = row_q;
    case (state_q)
      tsn_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = tsn_pkg::OP_ACCEPT;
        end
      end
      tsn_pkg::S_BOX:  cmd_o.op = tsn_pkg::OP_BOX;
      tsn_pkg::S_EDGE: cmd_o.op = tsn_pkg::OP_EDGE;
      tsn_pkg::S_MUL:  cmd_o.op = tsn_pkg::OP_MUL;
      tsn_pkg::S_MAX:  cmd_o.op = tsn_pkg::OP_MAX;
      tsn_pkg::S_NORM: cmd_o.op = tsn_pkg::OP_NORM;
      tsn_pkg::S_SQ:   cmd_o.op = tsn_pkg::OP_SQ;
      tsn_pkg::S_SQRT: cmd_o.op = tsn_pkg::OP_SQRT;
      tsn_pkg::S_DIV:  cmd_o.op = tsn_pkg::OP_DIV;
      tsn_pkg::S_EMIT: begin
        out_valid_o = 1'b1;
        last_o      = last_row;
      end
      default: cmd_o.op = tsn_pkg::OP_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsn_pkg::S_IDLE;
      cnt_q   <= '0;
      row_q   <= tsn_pkg::ROW_P0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      row_q   <= row_d;
    end
  end

endmodule
`default_nettype wire

>>> sv/tsn_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module tsn_dp #(
  parameter int unsigned TRIANGLE_CAPACITY = 65536,
  parameter int unsigned OBJECT_CAPACITY   = 4096
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire tsn_pkg::cmd_t                    cmd_i,
  output tsn_pkg::sts_t                         sts_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [tsn_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [tsn_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                             command_i,
  input  wire logic signed [31:0]               a_x_i,
  input  wire logic signed [31:0]               a_y_i,
  input  wire logic signed [31:0]               a_z_i,
  input  wire logic signed [31:0]               b_x_i,
  input  wire logic signed [31:0]               b_y_i,
  input  wire logic signed [31:0]               b_z_i,
  input  wire logic signed [31:0]               c_x_i,
  input  wire logic signed [31:0]               c_y_i,
  input  wire logic signed [31:0]               c_z_i,
  output logic [15:0]                           slot_o,
  output logic signed [31:0]                    vec_x_o,
  output logic signed [31:0]                    vec_y_o,
  output logic signed [31:0]                    vec_z_o,
  output logic [15:0]                           start_slot_o,
  output logic [16:0]                           triangle_total_o,
  output logic [7:0]                            material_out_o,
  output logic [15:0]                           tag_out_o
);

  localparam int unsigned TCW = ($clog2(TRIANGLE_CAPACITY + 1) > 18) ?
                                $clog2(TRIANGLE_CAPACITY + 1) : 18;
  localparam int unsigned OCW = ($clog2(OBJECT_CAPACITY + 1) > 13) ?
                                $clog2(OBJECT_CAPACITY + 1) : 13;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return s[31:0];
  endfunction

  // configuration registers
  logic signed [31:0] off_q [3];
  logic [7:0]         mat_q;
  logic [15:0]        tag_q;
  logic [16:0]        mesh_tri_q;
  logic [16:0]        max_tri_q;
  logic [12:0]        max_obj_q;

  // scene state
  logic [16:0]        tu_q;
  logic [12:0]        ou_q;
  logic [16:0]        prog_q;
  logic               rej_q;
  logic signed [31:0] bmin_q [3];
  logic signed [31:0] bmax_q [3];

  // per item data
  logic signed [31:0] p_q [9];
  logic [15:0]        tslot_q, oslot_q, sslot_q;
  logic [16:0]        total_q;
  logic               ending_q;
  logic signed [32:0] e33_q [6];
  logic signed [31:0] e_q [6];
  logic signed [63:0] prod_q;
  logic [2:0]         ptag_q;
  logic               pv_q, psq_q;
  logic signed [64:0] c_q [3];
  logic [63:0]        m_q;
  logic [63:0]        s2_q;
  logic [63:0]        sx_q;
  logic [34:0]        srem_q;
  logic [31:0]        sroot_q;
  logic [46:0]        dnum_q [3];
  logic [31:0]        drem_q [3];
  logic [46:0]        dq_q [3];

  // accept side values
  logic signed [31:0] vin [9];
  logic signed [31:0] vsat [9];
  logic [16:0]        count;
  logic [TCW-1:0]     tri_lim;
  logic [OCW-1:0]     obj_lim;
  logic               start, rej_new, rej_now, ending;
  logic [17:0]        tu_sum;
  logic [16:0]        prog_inc;

  assign vin[0] = a_x_i; assign vin[1] = a_y_i; assign vin[2] = a_z_i;
  assign vin[3] = b_x_i; assign vin[4] = b_y_i; assign vin[5] = b_z_i;
  assign vin[6] = c_x_i; assign vin[7] = c_y_i; assign vin[8] = c_z_i;

  // translate with saturation
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        vsat[i*3+j] = sat_add(vin[i*3+j], off_q[j]);
      end
    end
  end

  // mesh start, capacity check and end of mesh
  always_comb begin
    if (mesh_tri_q == 17'd0) count = 17'd1;
    else if (mesh_tri_q > 17'h10000) count = 17'h10000;
    else count = mesh_tri_q;
    tri_lim  = (TCW'(max_tri_q) < TCW'(TRIANGLE_CAPACITY)) ? TCW'(max_tri_q) :
               TCW'(TRIANGLE_CAPACITY);
    obj_lim  = (OCW'(max_obj_q) < OCW'(OBJECT_CAPACITY)) ? OCW'(max_obj_q) :
               OCW'(OBJECT_CAPACITY);
    start    = (prog_q == 17'd0);
    rej_new  = ((TCW'(tu_q) + TCW'(count)) > tri_lim) || (OCW'(ou_q) >= obj_lim);
    rej_now  = start ? rej_new : rej_q;
    prog_inc = prog_q + 17'd1;
    ending   = ({1'b0, prog_q} + 18'd1) >= {1'b0, count};
    tu_sum   = {1'b0, tu_q} + {1'b0, prog_inc};
  end

  // multiplier operand select
  logic signed [31:0] mul_a, mul_b;
  logic               mul_issue;
  always_comb begin
    mul_a = e_q[1];
    mul_b = e_q[5];
    mul_issue = 1'b0;
    if (cmd_i.op == tsn_pkg::OP_SQ) begin
      mul_a = c_q[cmd_i.idx[1:0]][31:0];
      mul_b = c_q[cmd_i.idx[1:0]][31:0];
      mul_issue = cmd_i.idx < tsn_pkg::CNT_W'(tsn_pkg::SQ_STEPS);
    end else begin
      case (cmd_i.idx[2:0])
        3'd0: begin mul_a = e_q[1]; mul_b = e_q[5]; end
        3'd1: begin mul_a = e_q[2]; mul_b = e_q[4]; end
        3'd2: begin mul_a = e_q[2]; mul_b = e_q[3]; end
        3'd3: begin mul_a = e_q[0]; mul_b = e_q[5]; end
        3'd4: begin mul_a = e_q[0]; mul_b = e_q[4]; end
        3'd5: begin mul_a = e_q[1]; mul_b = e_q[3]; end
        default: begin mul_a = e_q[1]; mul_b = e_q[5]; end
      endcase
      mul_issue = (cmd_i.op == tsn_pkg::OP_MUL) &&
                  (cmd_i.idx < tsn_pkg::CNT_W'(tsn_pkg::MUL_STEPS));
    end
  end

  // largest cross product magnitude
  logic [63:0] cmag [3];
  logic [63:0] mmax;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cmag[i] = c_q[i][64] ? 64'(-c_q[i]) : 64'(c_q[i]);
    end
    mmax = cmag[0];
    if (cmag[1] > mmax) mmax = cmag[1];
    if (cmag[2] > mmax) mmax = cmag[2];
  end

  logic norm_done;
  assign norm_done = ((m_q[63:30] == '0) && m_q[29]) || (m_q == '0);

  // square root step
  logic [34:0] sq_rem_prev, sq_rem_cat, sq_trial;
  logic [31:0] sq_root_prev;
  logic [63:0] sq_x;
  always_comb begin
    sq_rem_prev  = (cmd_i.idx == '0) ? '0 : srem_q;
    sq_root_prev = (cmd_i.idx == '0) ? '0 : sroot_q;
    sq_x         = (cmd_i.idx == '0) ? s2_q : sx_q;
    sq_rem_cat   = {sq_rem_prev[32:0], sq_x[63:62]};
    sq_trial     = {1'b0, sq_root_prev, 2'b01};
  end

  // divider lanes
  logic [31:0] dl;
  logic [46:0] dnum_prev [3];
  logic [31:0] drem_prev [3];
  logic [46:0] dq_prev [3];
  logic [32:0] drem_cat [3];
  logic [63:0] cabs [3];
  always_comb begin
    dl = (sroot_q == '0) ? 32'd1 : sroot_q;
    for (int i = 0; i < 3; i++) begin
      cabs[i]      = c_q[i][64] ? 64'(-c_q[i]) : 64'(c_q[i]);
      dnum_prev[i] = (cmd_i.idx == '0) ?
                     ({cabs[i][30:0], 16'd0} + 47'(dl >> 1)) : dnum_q[i];
      drem_prev[i] = (cmd_i.idx == '0) ? '0 : drem_q[i];
      dq_prev[i]   = (cmd_i.idx == '0) ? '0 : dq_q[i];
      drem_cat[i]  = {drem_prev[i], dnum_prev[i][46]};
    end
  end

  // configuration and scene state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < 3; j++) begin
        off_q[j]  <= '0;
        bmin_q[j] <= tsn_pkg::BOX_MIN_INIT;
        bmax_q[j] <= tsn_pkg::BOX_MAX_INIT;
      end
      mat_q      <= '0;
      tag_q      <= '0;
      mesh_tri_q <= 17'd1;
      max_tri_q  <= 17'h10000;
      max_obj_q  <= 13'd4096;
      tu_q       <= '0;
      ou_q       <= '0;
      prog_q     <= '0;
      rej_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tsn_pkg::CFG_OFFSET_X:       off_q[0]   <= cfg_data_i;
          tsn_pkg::CFG_OFFSET_Y:       off_q[1]   <= cfg_data_i;
          tsn_pkg::CFG_OFFSET_Z:       off_q[2]   <= cfg_data_i;
          tsn_pkg::CFG_MATERIAL_ID:    mat_q      <= cfg_data_i[7:0];
          tsn_pkg::CFG_OBJECT_TAG:     tag_q      <= cfg_data_i[15:0];
          tsn_pkg::CFG_MESH_TRIANGLES: mesh_tri_q <= cfg_data_i[16:0];
          tsn_pkg::CFG_MAX_TRIANGLES:  max_tri_q  <= cfg_data_i[16:0];
          tsn_pkg::CFG_MAX_OBJECTS:    max_obj_q  <= cfg_data_i[12:0];
          default: ;
        endcase
      end
      if (cmd_i.op == tsn_pkg::OP_ACCEPT) begin
        if (command_i == tsn_pkg::CMD_CLEAR) begin
          tu_q   <= '0;
          ou_q   <= '0;
          prog_q <= '0;
          rej_q  <= 1'b0;
          for (int j = 0; j < 3; j++) begin
            bmin_q[j] <= tsn_pkg::BOX_MIN_INIT;
            bmax_q[j] <= tsn_pkg::BOX_MAX_INIT;
          end
        end else begin
          if (start) begin
            for (int j = 0; j < 3; j++) begin
              bmin_q[j] <= tsn_pkg::BOX_MIN_INIT;
              bmax_q[j] <= tsn_pkg::BOX_MAX_INIT;
            end
          end
          if (rej_now) begin
            prog_q <= ending ? '0 : prog_inc;
            rej_q  <= !ending;
          end else if (ending) begin
            tu_q   <= tu_sum[17] ? 17'h1FFFF : tu_sum[16:0];
            ou_q   <= ou_q + 13'd1;
            prog_q <= '0;
            rej_q  <= 1'b0;
          end else begin
            prog_q <= prog_inc;
            rej_q  <= 1'b0;
          end
        end
      end else if (cmd_i.op == tsn_pkg::OP_BOX) begin
        // grow the box by this triangle
        for (int j = 0; j < 3; j++) begin
          logic signed [31:0] mn, mx;
          mn = bmin_q[j];
          mx = bmax_q[j];
          for (int i = 0; i < 3; i++) begin
            if (p_q[i*3+j] < mn) mn = p_q[i*3+j];
            if (p_q[i*3+j] > mx) mx = p_q[i*3+j];
          end
          bmin_q[j] <= mn;
          bmax_q[j] <= mx;
        end
      end
    end
  end

  // normal datapath
  always_ff @(posedge clk_i) begin
    pv_q   <= mul_issue;
    ptag_q <= cmd_i.idx[2:0];
    psq_q  <= (cmd_i.op == tsn_pkg::OP_SQ);
    if (mul_issue) begin
      prod_q <= mul_a * mul_b;
    end
    // accumulate the registered product
    if (pv_q) begin
      if (psq_q) begin
        s2_q <= s2_q + 64'(prod_q);
      end else if (!ptag_q[0]) begin
        c_q[ptag_q[2:1]] <= 65'(prod_q);
      end else begin
        c_q[ptag_q[2:1]] <= c_q[ptag_q[2:1]] - 65'(prod_q);
      end
    end
    case (cmd_i.op)
      tsn_pkg::OP_ACCEPT: begin
        for (int i = 0; i < 9; i++) p_q[i] <= vsat[i];
        tslot_q  <= 16'(tu_q + prog_q);
        oslot_q  <= 16'(ou_q);
        sslot_q  <= tu_q[15:0];
        total_q  <= prog_inc;
        ending_q <= ending;
      end
      tsn_pkg::OP_BOX: begin
        for (int j = 0; j < 3; j++) begin
          e33_q[j]   <= {p_q[3+j][31], p_q[3+j]} - {p_q[j][31], p_q[j]};
          e33_q[3+j] <= {p_q[6+j][31], p_q[6+j]} - {p_q[j][31], p_q[j]};
        end
      end
      tsn_pkg::OP_EDGE: begin
        // one floor shift when any edge needs 32 magnitude bits
        logic big;
        big = 1'b0;
        for (int i = 0; i < 6; i++) begin
          if ((e33_q[i][32] != e33_q[i][31]) || (e33_q[i] == -33'sh8000_0000)) big = 1'b1;
        end
        for (int i = 0; i < 6; i++) begin
          e_q[i] <= big ? 32'(e33_q[i] >>> 1) : e33_q[i][31:0];
        end
      end
      tsn_pkg::OP_MAX: begin
        m_q  <= mmax;
        s2_q <= '0;
      end
      tsn_pkg::OP_NORM: begin
        // scale so the largest magnitude has exactly 30 bits
        if (m_q[63:30] != '0) begin
          m_q <= m_q >> 1;
          for (int i = 0; i < 3; i++) c_q[i] <= c_q[i] >>> 1;
        end else if (!m_q[29] && (m_q != '0)) begin
          m_q <= m_q << 1;
          for (int i = 0; i < 3; i++) c_q[i] <= c_q[i] <<< 1;
        end
      end
      tsn_pkg::OP_SQRT: begin
        sx_q <= {sq_x[61:0], 2'b00};
        if (sq_rem_cat >= sq_trial) begin
          srem_q  <= sq_rem_cat - sq_trial;
          sroot_q <= {sq_root_prev[30:0], 1'b1};
        end else begin
          srem_q  <= sq_rem_cat;
          sroot_q <= {sq_root_prev[30:0], 1'b0};
        end
      end
      tsn_pkg::OP_DIV: begin
        for (int i = 0; i < 3; i++) begin
          dnum_q[i] <= {dnum_prev[i][45:0], 1'b0};
          if (drem_cat[i] >= {1'b0, dl}) begin
            drem_q[i] <= 32'(drem_cat[i] - {1'b0, dl});
            dq_q[i]   <= {dq_prev[i][45:0], 1'b1};
          end else begin
            drem_q[i] <= drem_cat[i][31:0];
            dq_q[i]   <= {dq_prev[i][45:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  // normal components with sign
  logic signed [31:0] nrm [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (m_q == '0) nrm[i] = '0;
      else nrm[i] = c_q[i][64] ? -dq_q[i][31:0] : dq_q[i][31:0];
    end
  end

  assign sts_o.rej_now   = rej_now;
  assign sts_o.ending    = ending_q;
  assign sts_o.norm_done = norm_done;
  assign sts_o.zero      = (m_q == '0);

  // row payload select
  always_comb begin
    slot_o           = '0;
    vec_x_o          = '0;
    vec_y_o          = '0;
    vec_z_o          = '0;
    start_slot_o     = '0;
    triangle_total_o = '0;
    material_out_o   = '0;
    tag_out_o        = '0;
    case (cmd_i.row)
      tsn_pkg::ROW_P0: begin
        slot_o = tslot_q; vec_x_o = p_q[0]; vec_y_o = p_q[1]; vec_z_o = p_q[2];
      end
      tsn_pkg::ROW_P1: begin
        slot_o = tslot_q; vec_x_o = p_q[3]; vec_y_o = p_q[4]; vec_z_o = p_q[5];
      end
      tsn_pkg::ROW_P2: begin
        slot_o = tslot_q; vec_x_o = p_q[6]; vec_y_o = p_q[7]; vec_z_o = p_q[8];
      end
      tsn_pkg::ROW_NORMAL: begin
        slot_o = tslot_q; vec_x_o = nrm[0]; vec_y_o = nrm[1]; vec_z_o = nrm[2];
      end
      tsn_pkg::ROW_BOX_MIN: begin
        slot_o = oslot_q; vec_x_o = bmin_q[0]; vec_y_o = bmin_q[1]; vec_z_o = bmin_q[2];
      end
      tsn_pkg::ROW_BOX_MAX: begin
        slot_o = oslot_q; vec_x_o = bmax_q[0]; vec_y_o = bmax_q[1]; vec_z_o = bmax_q[2];
      end
      tsn_pkg::ROW_OBJECT: begin
        slot_o           = oslot_q;
        start_slot_o     = sslot_q;
        triangle_total_o = total_q;
        material_out_o   = mat_q;
        tag_out_o        = tag_q;
      end
      tsn_pkg::ROW_REJECT: slot_o = oslot_q;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/triangle_setup_normal_aabb.sv
`timescale 1ns / 1ps
`default_nettype none
// Triangle setup: translates each triangle's vertices by the configured offset (saturating),
// emits the three vertices and the unit face normal, grows the mesh bounding box and after the
// last triangle of a mesh emits box min, box max and the object record. A clear or a triangle of
// a rejected mesh takes one row. One item at a time: a kept triangle uses a shared 32x32
// multiplier for 9 products, up to 33 normalize shifts, a 32-step square root and a 47-step
// divider with three lanes before its result rows; a degenerate triangle skips the squaring,
// the root and the divider.
module triangle_setup_normal_aabb #(
  parameter int unsigned TRIANGLE_CAPACITY = 65536,
  parameter int unsigned OBJECT_CAPACITY   = 4096
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [tsn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [tsn_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           command_i,
  input  wire logic signed [31:0]             a_x_i,
  input  wire logic signed [31:0]             a_y_i,
  input  wire logic signed [31:0]             a_z_i,
  input  wire logic signed [31:0]             b_x_i,
  input  wire logic signed [31:0]             b_y_i,
  input  wire logic signed [31:0]             b_z_i,
  input  wire logic signed [31:0]             c_x_i,
  input  wire logic signed [31:0]             c_y_i,
  input  wire logic signed [31:0]             c_z_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [3:0]                          row_kind_o,
  output logic [15:0]                         slot_o,
  output logic signed [31:0]                  vec_x_o,
  output logic signed [31:0]                  vec_y_o,
  output logic signed [31:0]                  vec_z_o,
  output logic [15:0]                         start_slot_o,
  output logic [16:0]                         triangle_total_o,
  output logic [7:0]                          material_out_o,
  output logic [15:0]                         tag_out_o,
  output logic                                last_o
);

  tsn_pkg::cmd_t cmd;
  tsn_pkg::sts_t sts;

  // sequencer
  tsn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .last_o      (last_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // arithmetic and scene state
  tsn_dp #(
    .TRIANGLE_CAPACITY (TRIANGLE_CAPACITY),
    .OBJECT_CAPACITY   (OBJECT_CAPACITY)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .command_i        (command_i),
    .a_x_i            (a_x_i),
    .a_y_i            (a_y_i),
    .a_z_i            (a_z_i),
    .b_x_i            (b_x_i),
    .b_y_i            (b_y_i),
    .b_z_i            (b_z_i),
    .c_x_i            (c_x_i),
    .c_y_i            (c_y_i),
    .c_z_i            (c_z_i),
    .slot_o           (slot_o),
    .vec_x_o          (vec_x_o),
    .vec_y_o          (vec_y_o),
    .vec_z_o          (vec_z_o),
    .start_slot_o     (start_slot_o),
    .triangle_total_o (triangle_total_o),
    .material_out_o   (material_out_o),
    .tag_out_o        (tag_out_o)
  );

  assign row_kind_o = cmd.row;

endmodule
`default_nettype wire

>>> tb/tsn_checker.sv
`timescale 1ns / 1ps
module tsn_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        command_i,
  input  logic [31:0] a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i, c_x_i, c_y_i, c_z_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [3:0]  row_kind_i,
  input  logic [15:0] slot_i,
  input  logic [31:0] vec_x_i, vec_y_i, vec_z_i,
  input  logic [15:0] start_slot_i,
  input  logic [16:0] triangle_total_i,
  input  logic [7:0]  material_out_i,
  input  logic [15:0] tag_out_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          rows_pending_o
);
  import tsn_pkg::*;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] slot;
    logic [31:0] vx, vy, vz;
    logic [15:0] start;
    logic [16:0] total;
    logic [7:0]  mat;
    logic [15:0] tag;
    logic        last;
  } row_t;

  row_t rows_expected[$];

  // shadow registers and scene state
  logic [31:0] off_r[3];
  logic [7:0]  mat_r;
  logic [15:0] tag_r;
  logic [16:0] mesh_r, maxtri_r;
  logic [12:0] maxobj_r;
  logic [16:0] tri_used;
  logic [12:0] obj_used;
  logic [16:0] progress;
  logic        rejected;
  longint      bmin[3], bmax[3];

  assign rows_pending_o = rows_expected.size();

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic int nbits(longint unsigned v);
    int n;
    n = 0;
    while (v != 0) begin
      n++;
      v = v >> 1;
    end
    return n;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // unit face normal in Q16.16
  task automatic unit_normal(input longint p[3][3], output longint n[3]);
    longint e[2][3], c[3];
    longint unsigned m, s2, len, q;
    int b;
    m = 0;
    s2 = 0;
    for (int i = 0; i < 3; i++) begin
      e[0][i] = p[1][i] - p[0][i];
      e[1][i] = p[2][i] - p[0][i];
      for (int j = 0; j < 2; j++) if (absv(e[j][i]) > m) m = absv(e[j][i]);
    end
    b = nbits(m);
    if (b > 31)
      for (int j = 0; j < 2; j++)
        for (int i = 0; i < 3; i++) e[j][i] = fshift(e[j][i], b - 31);
    c[0] = e[0][1] * e[1][2] - e[0][2] * e[1][1];
    c[1] = e[0][2] * e[1][0] - e[0][0] * e[1][2];
    c[2] = e[0][0] * e[1][1] - e[0][1] * e[1][0];
    m = 0;
    for (int i = 0; i < 3; i++) if (absv(c[i]) > m) m = absv(c[i]);
    if (m == 0) begin
      n[0] = 0; n[1] = 0; n[2] = 0;
      return;
    end
    b = nbits(m);
    for (int i = 0; i < 3; i++) begin
      if (b > 30) c[i] = fshift(c[i], b - 30);
      else if (b < 30) c[i] = c[i] <<< (30 - b);
      s2 += c[i] * c[i];
    end
    len = int_sqrt(s2);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      q = (absv(c[i]) * 65536 + len / 2) / len;
      n[i] = c[i] < 0 ? -longint'(q) : longint'(q);
    end
  endtask

  function automatic row_t mk_row(logic [3:0] k, logic [15:0] s, longint x, longint y,
                                  longint z);
    row_t r;
    r = '0;
    r.kind = k;
    r.slot = s;
    r.vx = x[31:0];
    r.vy = y[31:0];
    r.vz = z[31:0];
    return r;
  endfunction

  task automatic clear_box();
    for (int i = 0; i < 3; i++) begin
      bmin[i] = 64'sd2147483647;
      bmax[i] = -64'sd2147483648;
    end
  endtask

  // predict the rows of one accepted item
  task automatic predict_rows(input logic cmd, input logic [31:0] v[9]);
    longint tri_lim, obj_lim, p[3][3], n[3], sum;
    logic [16:0] cnt, tot;
    logic ending;
    row_t r;
    tri_lim = maxtri_r > 65536 ? 65536 : maxtri_r;
    obj_lim = maxobj_r > 4096 ? 4096 : maxobj_r;
    cnt = mesh_r == 0 ? 17'd1 : (mesh_r > 65536 ? 17'd65536 : mesh_r);
    if (cmd == CMD_CLEAR) begin
      tri_used = 0;
      obj_used = 0;
      progress = 0;
      rejected = 0;
      clear_box();
      r = mk_row(ROW_CLEAR, 0, 0, 0, 0);
      r.last = 1;
      rows_expected.push_back(r);
      return;
    end
    if (progress == 0) begin
      clear_box();
      rejected = (longint'(tri_used) + cnt > tri_lim) || (obj_used >= obj_lim);
    end
    ending = (progress + 18'd1) >= cnt;
    if (rejected) begin
      r = mk_row(ROW_REJECT, 16'(obj_used), 0, 0, 0);
      r.last = 1;
      rows_expected.push_back(r);
      if (ending) begin
        progress = 0;
        rejected = 0;
      end else begin
        progress++;
      end
      return;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        sum = longint'($signed(v[i*3+j])) + longint'($signed(off_r[j]));
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        p[i][j] = sum;
        if (sum < bmin[j]) bmin[j] = sum;
        if (sum > bmax[j]) bmax[j] = sum;
      end
    unit_normal(p, n);
    for (int i = 0; i < 3; i++)
      rows_expected.push_back(mk_row(4'(i), 16'(tri_used + progress), p[i][0], p[i][1],
                                     p[i][2]));
    r = mk_row(ROW_NORMAL, 16'(tri_used + progress), n[0], n[1], n[2]);
    if (!ending) begin
      r.last = 1;
      rows_expected.push_back(r);
      progress++;
      return;
    end
    rows_expected.push_back(r);
    tot = progress + 1;
    rows_expected.push_back(mk_row(ROW_BOX_MIN, 16'(obj_used), bmin[0], bmin[1], bmin[2]));
    rows_expected.push_back(mk_row(ROW_BOX_MAX, 16'(obj_used), bmax[0], bmax[1], bmax[2]));
    r = mk_row(ROW_OBJECT, 16'(obj_used), 0, 0, 0);
    r.start = tri_used[15:0];
    r.total = tot;
    r.mat = mat_r;
    r.tag = tag_r;
    r.last = 1;
    rows_expected.push_back(r);
    if (32'(tri_used) + tot > 32'h1FFFF) tri_used = 17'h1FFFF;
    else tri_used = tri_used + tot;
    obj_used++;
    progress = 0;
    rejected = 0;
  endtask

  task automatic cmp(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s expected %h actual %h", name, e, a);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    row_t e;
    logic [31:0] v[9];
    if (!rst_ni) begin
      off_r = '{0, 0, 0};
      mat_r = 0;
      tag_r = 0;
      mesh_r = 1;
      maxtri_r = 65536;
      maxobj_r = 4096;
      tri_used = 0;
      obj_used = 0;
      progress = 0;
      rejected = 0;
      clear_box();
      fail_count_o = 0;
      rows_expected.delete();
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OFFSET_X:       off_r[0] = cfg_data_i;
          CFG_OFFSET_Y:       off_r[1] = cfg_data_i;
          CFG_OFFSET_Z:       off_r[2] = cfg_data_i;
          CFG_MATERIAL_ID:    mat_r = cfg_data_i[7:0];
          CFG_OBJECT_TAG:     tag_r = cfg_data_i[15:0];
          CFG_MESH_TRIANGLES: mesh_r = cfg_data_i[16:0];
          CFG_MAX_TRIANGLES:  maxtri_r = cfg_data_i[16:0];
          CFG_MAX_OBJECTS:    maxobj_r = cfg_data_i[12:0];
          default: ;
        endcase
      end
      // accepted input item
      if (in_valid_i && in_ready_i) begin
        v = '{a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i, c_x_i, c_y_i, c_z_i};
        predict_rows(command_i, v);
      end
      // accepted result item
      if (out_valid_i && out_ready_i) begin
        if (rows_expected.size() == 0) begin
          $error("unexpected row kind %0d", row_kind_i);
          fail_count_o++;
        end else begin
          e = rows_expected.pop_front();
          cmp("row_kind", e.kind, row_kind_i);
          cmp("slot", e.slot, slot_i);
          cmp("vec_x", e.vx, vec_x_i);
          cmp("vec_y", e.vy, vec_y_i);
          cmp("vec_z", e.vz, vec_z_i);
          cmp("start_slot", e.start, start_slot_i);
          cmp("triangle_total", e.total, triangle_total_i);
          cmp("material_out", e.mat, material_out_i);
          cmp("tag_out", e.tag, tag_out_i);
          cmp("last", e.last, last_i);
        end
      end
    end
  end
endmodule

>>> tb/tb_triangle_setup_normal_aabb.sv
`timescale 1ns / 1ps
module tb_triangle_setup_normal_aabb;
  import tsn_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_idx_i = 0;
  logic [31:0] cfg_data_i = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic        command_i = 0;
  logic [31:0] vin[9];
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic [3:0]  row_kind_o;
  logic [15:0] slot_o, start_slot_o, tag_out_o;
  logic [31:0] vec_x_o, vec_y_o, vec_z_o;
  logic [16:0] triangle_total_o;
  logic [7:0]  material_out_o;
  logic        last_o;
  int          fail_count, rows_pending;
  int          idle_pct_in = 0, stall_pct_out = 0;
  int          hold_off = 0;
  int          quiet_cycles = 0;

  initial for (int i = 0; i < 9; i++) vin[i] = 0;

  always #5 clk_i = ~clk_i;

  triangle_setup_normal_aabb DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .command_i,
    .a_x_i(vin[0]), .a_y_i(vin[1]), .a_z_i(vin[2]),
    .b_x_i(vin[3]), .b_y_i(vin[4]), .b_z_i(vin[5]),
    .c_x_i(vin[6]), .c_y_i(vin[7]), .c_z_i(vin[8]),
    .out_valid_o, .out_ready_i, .row_kind_o, .slot_o, .vec_x_o, .vec_y_o, .vec_z_o,
    .start_slot_o, .triangle_total_o, .material_out_o, .tag_out_o, .last_o
  );

  tsn_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .command_i,
    .a_x_i(vin[0]), .a_y_i(vin[1]), .a_z_i(vin[2]),
    .b_x_i(vin[3]), .b_y_i(vin[4]), .b_z_i(vin[5]),
    .c_x_i(vin[6]), .c_y_i(vin[7]), .c_z_i(vin[8]),
    .out_valid_i(out_valid_o), .out_ready_i, .row_kind_i(row_kind_o), .slot_i(slot_o),
    .vec_x_i(vec_x_o), .vec_y_i(vec_y_o), .vec_z_i(vec_z_o),
    .start_slot_i(start_slot_o), .triangle_total_i(triangle_total_o),
    .material_out_i(material_out_o), .tag_out_i(tag_out_o), .last_i(last_o),
    .fail_count_o(fail_count), .rows_pending_o(rows_pending)
  );

  // receiver side: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct_out);
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // register write once nothing is in flight
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk_i);
    in_valid_i <= 0;
    while (rows_pending != 0) @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  // offer one item and hold it until accepted; valid stays high until an idle draw in a later call, write_reg or drain
  task automatic send_item(logic cmd, logic [31:0] v[9]);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct_in) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    command_i <= cmd;
    for (int i = 0; i < 9; i++) vin[i] <= v[i];
    in_valid_i <= 1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 0;
    while (rows_pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(20) << 16;
      2: return 32'h7FFFFFFF - $urandom_range(3);
      3: return 32'h80000000 + $urandom_range(3);
      default: return $urandom() >>> $urandom_range(31);
    endcase
  endfunction

  task automatic send_tri(int mode);
    logic [31:0] v[9];
    for (int i = 0; i < 9; i++)
      v[i] = (mode == 5) ? rand_coord($urandom_range(4)) : rand_coord(mode);
    send_item(CMD_TRIANGLE, v);
  endtask

  task automatic send_clear();
    logic [31:0] v[9];
    for (int i = 0; i < 9; i++) v[i] = $urandom();
    send_item(CMD_CLEAR, v);
  endtask

  initial begin
    logic [31:0] v[9];
    repeat (9) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed: defaults, extremes, degenerate triangles
    v = '{default: 0};
    send_item(CMD_TRIANGLE, v);
    v = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
          32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h00000000};
    send_item(CMD_TRIANGLE, v);
    v = '{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0};
    send_item(CMD_TRIANGLE, v);
    v = '{0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h20000, 32'h20000, 32'h20000};
    send_item(CMD_TRIANGLE, v);
    v = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
          32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF};
    send_item(CMD_TRIANGLE, v);
    send_clear();
    drain();

    // saturating offsets, multi-triangle mesh
    write_reg(CFG_OFFSET_X, 32'h7FFFFFFF);
    write_reg(CFG_OFFSET_Y, 32'h80000000);
    write_reg(CFG_OFFSET_Z, 32'h00010000);
    write_reg(CFG_MATERIAL_ID, 8'hFF);
    write_reg(CFG_OBJECT_TAG, 16'hFFFF);
    write_reg(CFG_MESH_TRIANGLES, 3);
    repeat (6) send_tri(5);
    drain();

    // rejection by triangle capacity, then by object capacity, zero mesh size
    write_reg(CFG_MAX_TRIANGLES, 7);
    write_reg(CFG_MESH_TRIANGLES, 2);
    repeat (4) send_tri(1);
    write_reg(CFG_MAX_TRIANGLES, 17'h1FFFF);
    write_reg(CFG_MAX_OBJECTS, 3);
    write_reg(CFG_MESH_TRIANGLES, 0);
    repeat (3) send_tri(4);
    write_reg(CFG_MAX_OBJECTS, 0);
    send_tri(1);
    write_reg(CFG_MAX_OBJECTS, 13'h1FFF);
    write_reg(CFG_MESH_TRIANGLES, 17'h1FFFF);
    send_tri(0);
    send_clear();
    drain();

    // random phases with varied idling
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct_in = 0;  stall_pct_out = 0;  end
        1: begin idle_pct_in = 63; stall_pct_out = 0;  end
        2: begin idle_pct_in = 0;  stall_pct_out = 63; end
        default: begin idle_pct_in = 8; stall_pct_out = 8; end
      endcase
      write_reg(CFG_OFFSET_X, (ph == 4) ? 32'h80000000 : $urandom());
      write_reg(CFG_OFFSET_Y, (ph == 4) ? 32'h7FFFFFFF : $urandom() >>> 8);
      write_reg(CFG_OFFSET_Z, (ph == 0) ? 32'h0 : $urandom());
      write_reg(CFG_MATERIAL_ID, $urandom_range(255));
      write_reg(CFG_OBJECT_TAG, $urandom_range(65535));
      write_reg(CFG_MESH_TRIANGLES, $urandom_range(1, 4));
      write_reg(CFG_MAX_TRIANGLES, (ph == 6) ? 17'd12 : 17'd65536);
      write_reg(CFG_MAX_OBJECTS, (ph == 7) ? 13'd4 : 13'd4096);
      if (ph == 2) hold_off = 400;
      for (int k = 0; k < 20; k++) begin
        if ($urandom_range(30) == 0) send_clear();
        else send_tri($urandom_range(5));
      end
      drain();
    end

    idle_pct_in = 0;
    stall_pct_out = 0;
    drain();
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
